// ===== rtl/core/hashed_page_table_insert_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hashed page table insert core
// Shared property forms, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HASHED_PAGE_TABLE_INSERT_CORE_ASSERT_SVH
`define HASHED_PAGE_TABLE_INSERT_CORE_ASSERT_SVH

// Same-cycle implication.
`define HPTI_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication.
`define HPTI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/hpti_pkg.sv =====
// ----------------------------------------------------------------------------
// Hashed page table insert package
// Request and response payloads, compare result and fixed field constants.
// ----------------------------------------------------------------------------
package hpti_pkg;

	localparam int TAG_W         = 32;
	localparam int SEG_W         = 24;
	localparam int TAG_VALID_BIT = 31;
	localparam logic [SEG_W-1:0] SEG_BASE_RESET = 24'h000400;

	// Slot choice codes
	localparam logic [1:0] REASON_MATCH = 2'd0;
	localparam logic [1:0] REASON_FREE  = 2'd1;
	localparam logic [1:0] REASON_EVICT = 2'd2;

	typedef struct packed {
		logic [31:0] effective_address;
		logic [31:0] physical_address;
		logic [11:0] page_mode;
	} req_t;

	typedef struct packed {
		logic [9:0]  group_number;
		logic [2:0]  slot_number;
		logic [1:0]  slot_reason;
		logic [31:0] tag_word;
		logic [31:0] data_word;
		logic [31:0] tlb_flush_address;
	} rsp_t;

	typedef struct packed {
		logic hit;
		logic free;
	} cmp_res_t;

endpackage

// ===== rtl/core/hpti_way_cmp.sv =====
// ----------------------------------------------------------------------------
// Way compare unit
// Shared tag comparator, applied to one way of the group per cycle.
// ----------------------------------------------------------------------------
module hpti_way_cmp (
	input  logic [hpti_pkg::TAG_W-1:0] entry_tag,
	input  logic [hpti_pkg::TAG_W-1:0] new_tag,
	output hpti_pkg::cmp_res_t         res
);
	import hpti_pkg::*;

	always_comb begin
		res.hit  = (entry_tag == new_tag);
		res.free = ~entry_tag[TAG_VALID_BIT];
	end

endmodule

// ===== rtl/core/hpti_table.sv =====
// ----------------------------------------------------------------------------
// Page table tag store
// One row per group holding all tags; registered read, full-row write,
// and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module hpti_table #(
	parameter int GROUP_INDEX_BITS = 10,
	parameter int WAYS             = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic                                wr_en,
	input  logic [GROUP_INDEX_BITS-1:0]         addr,
	input  logic [WAYS*hpti_pkg::TAG_W-1:0]     wr_row,
	output logic [WAYS*hpti_pkg::TAG_W-1:0]     rd_row,
	output logic                                clr_busy
);
	import hpti_pkg::*;

	localparam int ROWS  = 1 << GROUP_INDEX_BITS;
	localparam int ROW_W = WAYS * TAG_W;

	logic [ROW_W-1:0]            mem [ROWS];
	logic [ROW_W-1:0]            rd_row_q;
	logic [GROUP_INDEX_BITS-1:0] clr_addr_q;
	logic                        clr_busy_q;

	// clearing sweep: one row per cycle from reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {GROUP_INDEX_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem[addr];
		end
	end

	assign rd_row   = rd_row_q;
	assign clr_busy = clr_busy_q;

endmodule

// ===== rtl/core/hashed_page_table_insert_core.sv =====
// ----------------------------------------------------------------------------
// Hashed page table insert core
// Installs one address translation per request into a hashed page table of
// 2^GROUP_INDEX_BITS groups of WAYS entries and reports the slot it used.
// ----------------------------------------------------------------------------
// Requests are handled one at a time by the single tag comparator: after a
// hash step and a row read, it walks the WAYS tags of the hashed group one
// per cycle; the row is then written back and the response register loaded.
// A new request is accepted only once the previous one has loaded its
// response. The response register decouples the sides: a new request is
// accepted while the previous response still waits to be taken. After reset
// the table runs a clearing sweep over every group, one group per cycle,
// during which req_ready stays low; configuration writes are taken at any
// time. Write segment_id_base only while no request is in flight. Slot
// choice: a valid entry with the same tag word first, else the lowest
// invalid entry, else the entry at a round-robin pointer that then advances.
// ----------------------------------------------------------------------------
module hashed_page_table_insert_core #(
	parameter int GROUP_INDEX_BITS = 10,
	parameter int WAYS             = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// translation requests
	input  logic                         req_valid,
	output logic                         req_ready,
	input  hpti_pkg::req_t               req,
	// insert responses
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output hpti_pkg::rsp_t               rsp,
	// segment id base register
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hpti_pkg::SEG_W-1:0]   cfg_data
);
	import hpti_pkg::*;

	localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W    = WAYS * TAG_W;

	// one-hot sequencer
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_HASH  = 6'b000010,
		S_READ  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_WRITE = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                      state_q;
	logic [SEG_W-1:0]            seg_base_q;
	logic [WAY_BITS-1:0]         evict_q;
	logic [WAY_BITS-1:0]         way_q;
	logic                        hit_found_q;
	logic [WAY_BITS-1:0]         hit_slot_q;
	logic                        free_found_q;
	logic [WAY_BITS-1:0]         free_slot_q;
	logic                        rsp_valid_q;

	// payload registers
	req_t                        req_q;
	logic [TAG_W-1:0]            tag_q;
	logic [GROUP_INDEX_BITS-1:0] group_q;
	logic [WAY_BITS-1:0]         slot_q;
	logic [1:0]                  reason_q;
	rsp_t                        rsp_q;

	logic [SEG_W-1:0]            seg;
	logic [SEG_W-1:0]            hash_full;
	logic [TAG_W-1:0]            entry_tag;
	cmp_res_t                    cmp_res;
	logic [ROW_W-1:0]            rd_row;
	logic [ROW_W-1:0]            wr_row;
	logic                        clr_busy;
	logic [WAY_BITS-1:0]         slot_sel;
	logic [1:0]                  reason_sel;
	logic                        rsp_free;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE) && !clr_busy;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// segment id and primary hash; the sum wraps at 24 bits
	assign seg       = SEG_W'(req_q.effective_address[31:28]) + seg_base_q;
	assign hash_full = seg ^ {8'd0, req_q.effective_address[27:12]};

	// tag of the way under test
	assign entry_tag = rd_row[way_q*TAG_W +: TAG_W];

	hpti_way_cmp u_cmp (
		.entry_tag (entry_tag),
		.new_tag   (tag_q),
		.res       (cmp_res)
	);

	hpti_table #(
		.GROUP_INDEX_BITS (GROUP_INDEX_BITS),
		.WAYS             (WAYS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (state_q == S_READ),
		.wr_en    (state_q == S_WRITE),
		.addr     (group_q),
		.wr_row   (wr_row),
		.rd_row   (rd_row),
		.clr_busy (clr_busy)
	);

	// slot choice: matching tag, then free entry, then round-robin victim
	always_comb begin
		if (hit_found_q) begin
			slot_sel   = hit_slot_q;
			reason_sel = REASON_MATCH;
		end else if (free_found_q) begin
			slot_sel   = free_slot_q;
			reason_sel = REASON_FREE;
		end else begin
			slot_sel   = evict_q;
			reason_sel = REASON_EVICT;
		end
	end

	// replace the chosen way in the row read earlier
	always_comb begin
		wr_row = rd_row;
		wr_row[slot_sel*TAG_W +: TAG_W] = tag_q;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_base_q <= SEG_BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			seg_base_q <= cfg_data;
		end
	end

	// response valid: raise on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// sequencer and scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			evict_q      <= '0;
			way_q        <= '0;
			hit_found_q  <= 1'b0;
			hit_slot_q   <= '0;
			free_found_q <= 1'b0;
			free_slot_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					state_q <= S_READ;
				end
				S_READ: begin
					way_q        <= '0;
					hit_found_q  <= 1'b0;
					free_found_q <= 1'b0;
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					// keep the lowest way of each kind
					if (cmp_res.hit && !hit_found_q) begin
						hit_found_q <= 1'b1;
						hit_slot_q  <= way_q;
					end
					if (cmp_res.free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_slot_q  <= way_q;
					end
					if (way_q == WAY_BITS'(WAYS - 1)) begin
						state_q <= S_WRITE;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				S_WRITE: begin
					// advance the victim pointer on eviction only
					if (reason_sel == REASON_EVICT) begin
						if (evict_q == WAY_BITS'(WAYS - 1)) begin
							evict_q <= '0;
						end else begin
							evict_q <= evict_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the response register frees up
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == S_HASH) begin
			tag_q   <= {1'b1, seg, 1'b0, req_q.effective_address[27:22]};
			group_q <= hash_full[GROUP_INDEX_BITS-1:0];
		end
		if (state_q == S_WRITE) begin
			slot_q   <= slot_sel;
			reason_q <= reason_sel;
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.group_number      <= 10'(group_q);
			rsp_q.slot_number       <= 3'(slot_q);
			rsp_q.slot_reason       <= reason_q;
			rsp_q.tag_word          <= tag_q;
			rsp_q.data_word         <= {req_q.physical_address[31:12], req_q.page_mode};
			rsp_q.tlb_flush_address <= req_q.effective_address;
		end
	end

endmodule

// ===== rtl/core/hpti_checker.sv =====
// ----------------------------------------------------------------------------
// Hashed page table insert checker
// Port-level properties of the insert core, bound to the top level.
// ----------------------------------------------------------------------------
`include "hashed_page_table_insert_core_assert.svh"

module hpti_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input hpti_pkg::rsp_t rsp
);
	import hpti_pkg::*;

	// a stalled response holds
	`HPTI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// busy right after a request is taken
	`HPTI_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

	// no response is loaded while an accepted request is in its hash step
	`HPTI_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready, ##1 !$rose(rsp_valid))

	// tag word is valid, primary hash, and carries the address page bits
	`HPTI_ASSERT_IMPL(a_tag_form, rsp_valid, rsp.tag_word[TAG_VALID_BIT] && !rsp.tag_word[6])
	`HPTI_ASSERT_IMPL(a_tag_page, rsp_valid, rsp.tag_word[5:0] == rsp.tlb_flush_address[27:22])

	// slot reason is one of the defined codes
	`HPTI_ASSERT_IMPL(a_reason_code, rsp_valid, rsp.slot_reason <= REASON_EVICT)

endmodule

bind hashed_page_table_insert_core hpti_checker u_hpti_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Hashed page table insert core testbench
// Drives translation requests through the valid/ready request port and checks
// every insert response against a cycle-free predictor of the hashed table.
// The predictor keeps its own tag mirror, eviction pointer and segment base.
// A directed run covers slot reuse, free fill and eviction wrap. Random
// phases then follow under several segment bases and back-pressure mixes.
// ----------------------------------------------------------------------------
module tb;
	import hpti_pkg::*;

	localparam int GROUP_BITS  = 10;
	localparam int WAY_COUNT   = 8;
	localparam int ROWS        = (1 << GROUP_BITS) * WAY_COUNT;
	localparam int PHASE_ITEMS = 420;
	localparam int SETTLE      = 2 * (WAY_COUNT + 5);
	// clearing sweep plus ~1700 requests at worst-case stall mix, several times over
	localparam int CYCLE_LIMIT = 400000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cfg_data  = '0;

	// request stream, expected responses and predictor state
	req_t        pending_translations[$];
	rsp_t        expected_inserts[$];
	logic [31:0] tag_mirror [ROWS];
	logic [2:0]  evict_ptr_model;
	logic [23:0] seg_base_model;

	// stimulus knobs owned by the sequencing block
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic [23:0] gen_base;
	logic [9:0]  hot_groups [4];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	hashed_page_table_insert_core #(
		.GROUP_INDEX_BITS(GROUP_BITS),
		.WAYS(WAY_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what);
		$display("tb: mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Predict one insert: build the tag, pick the slot, update the mirror.
	function automatic rsp_t install_translation(input req_t r);
		rsp_t        res;
		logic [23:0] seg;
		logic [31:0] tag;
		int unsigned row_base;
		bit          placed;
		seg = seg_base_model + 24'(r.effective_address[31:28]);
		tag = {1'b1, seg, 1'b0, r.effective_address[27:22]};
		res.group_number = seg[GROUP_BITS-1:0] ^ r.effective_address[12 +: GROUP_BITS];
		row_base = res.group_number * WAY_COUNT;
		placed = 1'b0;
		// reuse the lowest entry carrying the same tag word
		for (int i = 0; i < WAY_COUNT; i++) begin
			if (!placed && tag_mirror[row_base + i] == tag) begin
				res.slot_number = 3'(i);
				res.slot_reason = REASON_MATCH;
				placed = 1'b1;
			end
		end
		// else take the lowest invalid entry
		for (int i = 0; i < WAY_COUNT; i++) begin
			if (!placed && !tag_mirror[row_base + i][TAG_VALID_BIT]) begin
				res.slot_number = 3'(i);
				res.slot_reason = REASON_FREE;
				placed = 1'b1;
			end
		end
		// else evict at the shared pointer and advance it
		if (!placed) begin
			res.slot_number = evict_ptr_model;
			res.slot_reason = REASON_EVICT;
			evict_ptr_model = (evict_ptr_model == 3'(WAY_COUNT - 1)) ? 3'd0 : evict_ptr_model + 3'd1;
		end
		tag_mirror[row_base + res.slot_number] = tag;
		res.tag_word = tag;
		res.data_word = {r.physical_address[31:12], r.page_mode};
		res.tlb_flush_address = r.effective_address;
		return res;
	endfunction

	// Build an effective address that hashes to the given group under a base.
	function automatic logic [31:0] ea_for(input logic [23:0] base, input logic [3:0] top,
		input logic [5:0] abbrev, input logic [9:0] grp, input logic [11:0] offset);
		logic [23:0] seg;
		seg = base + 24'(top);
		return {top, abbrev, grp ^ seg[9:0], offset};
	endfunction

	task automatic queue_translation(input logic [31:0] ea, input logic [31:0] pa,
		input logic [11:0] mode);
		req_t r;
		r.effective_address = ea;
		r.physical_address = pa;
		r.page_mode = mode;
		pending_translations.push_back(r);
	endtask

	// Mostly concentrate requests on a few hot groups with a small tag set,
	// so matches, free fills and evictions all recur; the rest is fully random.
	task automatic queue_random_phase(input int unsigned count);
		logic [31:0] ea;
		foreach (hot_groups[i]) hot_groups[i] = 10'($urandom_range(1023));
		repeat (count) begin
			if ($urandom_range(99) < 20)
				ea = $urandom;
			else
				ea = ea_for(gen_base, 4'($urandom_range(1)), 6'($urandom_range(5)),
					hot_groups[$urandom_range(3)], 12'($urandom_range(4095)));
			queue_translation(ea, $urandom, 12'($urandom_range(4095)));
		end
	endtask

	// Hold until every request is accepted and every response has come back.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_translations.size() != 0 || req_valid || expected_inserts.size() != 0);
	endtask

	task automatic write_seg_base(input logic [23:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		gen_base = value;
	endtask

	// Request driver: offer the next request only once the held one is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (pending_translations.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_translations.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response sink: stall at the configured rate.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Acceptance monitor: track register writes and predict each request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				seg_base_model = cfg_data;
			if (req_valid && req_ready)
				expected_inserts.push_back(install_translation(req));
		end
	end

	// Response monitor: compare field by field against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_inserts.size() == 0) begin
				report_mismatch($sformatf("response with nothing pending, flush %h",
					rsp.tlb_flush_address));
			end else begin
				want = expected_inserts.pop_front();
				if (rsp.group_number !== want.group_number)
					report_mismatch($sformatf("group_number got %h want %h",
						rsp.group_number, want.group_number));
				if (rsp.slot_number !== want.slot_number)
					report_mismatch($sformatf("slot_number got %h want %h",
						rsp.slot_number, want.slot_number));
				if (rsp.slot_reason !== want.slot_reason)
					report_mismatch($sformatf("slot_reason got %h want %h",
						rsp.slot_reason, want.slot_reason));
				if (rsp.tag_word !== want.tag_word)
					report_mismatch($sformatf("tag_word got %h want %h",
						rsp.tag_word, want.tag_word));
				if (rsp.data_word !== want.data_word)
					report_mismatch($sformatf("data_word got %h want %h",
						rsp.data_word, want.data_word));
				if (rsp.tlb_flush_address !== want.tlb_flush_address)
					report_mismatch($sformatf("tlb_flush_address got %h want %h",
						rsp.tlb_flush_address, want.tlb_flush_address));
			end
		end
	end

	// Watchdog: end the run with an error verdict once cycle_count reaches CYCLE_LIMIT.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		foreach (tag_mirror[i]) tag_mirror[i] = '0;
		evict_ptr_model = '0;
		seg_base_model = SEG_BASE_RESET;
		gen_base = SEG_BASE_RESET;
		send_idle_pct = 21;
		recv_stall_pct = 65;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, then a tag match on group 0.
		queue_translation(32'h0000_0000, 32'h0000_0000, 12'h000);
		queue_translation(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
		queue_translation(32'h0000_0000, 32'h5A5A_5A5A, 12'hA5A);
		// Fill group 5 with eight distinct tags, then two evictions.
		for (int i = 0; i < 10; i++)
			queue_translation(ea_for(gen_base, 4'd2, 6'(i), 10'd5, 12'(i)),
				$urandom, 12'($urandom_range(4095)));
		// Reuse a survivor, then a tag that landed on an evicted slot.
		queue_translation(ea_for(gen_base, 4'd2, 6'd3, 10'd5, 12'h123), $urandom, 12'h0F0);
		queue_translation(ea_for(gen_base, 4'd2, 6'd8, 10'd5, 12'h456), $urandom, 12'h00F);
		// Evict across the end of the group so the pointer wraps to slot 0.
		for (int i = 10; i < 17; i++)
			queue_translation(ea_for(gen_base, 4'd2, 6'(i), 10'd5, 12'h000),
				$urandom, 12'($urandom_range(4095)));
		wait_drained();

		write_seg_base(24'h000000);
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		// Swap the idling sides.
		send_idle_pct = 65;
		recv_stall_pct = 21;
		write_seg_base(24'hFFFFF0);
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		write_seg_base(24'($urandom_range(16777200, 1)));
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		// Full throughput on both sides.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_seg_base(24'($urandom_range(16777200, 1)));
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		// Let any stray response surface before the verdict.
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
